>>> design/line_pixel_rasterizer_defines.svh
// Assertion macros shared by the line rasteriser.
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line rasteriser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line rasteriser: next-cycle check failed");

`endif

>>> design/lpr_pkg.sv
package lpr_pkg;

  localparam int COORD_BITS = 6;
  // Error term spans roughly -2*dmajor .. +2*dmajor, plus sign.
  localparam int ERR_BITS = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic single;
    logic final_step;
  } dp_stat_t;

endpackage

>>> design/line_pixel_rasterizer.sv
// Line rasteriser: give it two endpoints and it emits every pixel of the
// straight line between them, start point first, using the exact integer
// form of the classic error-term walk along the major axis. A line is
// accepted on a clock edge where start is high and busy is low. The first
// pixel appears on the result ports in the cycle after acceptance, and the
// following pixels come in the consecutive cycles with no gaps, one beat per
// cycle, each marked by strobe for exactly one cycle; last flags the final
// beat. A line whose larger coordinate difference is d yields d + 1 beats,
// from 1 for equal endpoints to 64 for a full diagonal or axis-length
// line. The single step unit in the datapath advances the major coordinate
// by one per cycle. Busy stays high while further pixels of the current
// line remain, and drops in the cycle that carries the last beat, so the
// next line can be taken then and its first pixel follows directly. The
// receiver cannot stall: it must take each beat in the cycle it is
// presented.
`include "line_pixel_rasterizer_defines.svh"

module line_pixel_rasterizer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lpr_pkg::coord_t x_start,
  input  lpr_pkg::coord_t y_start,
  input  lpr_pkg::coord_t x_end,
  input  lpr_pkg::coord_t y_end,
  output logic            strobe,
  output lpr_pkg::coord_t pixel_x,
  output lpr_pkg::coord_t pixel_y,
  output logic            last
);

  // Commands from the sequencer and status back from the datapath.
  lpr_pkg::dp_cmd_t  cmd;
  lpr_pkg::dp_stat_t stat;

  // The sequencer owns the handshake and the beat strobe.
  lpr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .cmd    (cmd),
    .stat   (stat)
  );

  // The datapath holds the line set-up, the error term and the pixel
  // output registers.
  lpr_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .stat    (stat),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .last    (last)
  );

  // An accepted line always produces a beat in the next cycle.
  `LPR_ASSERT_NEXT(a_accept_gives_beat, clk, rst, start && !busy, strobe)
  // Beats of one line are contiguous until the last one.
  `LPR_ASSERT_NEXT(a_beats_contiguous, clk, rst, strobe && !last, strobe)
  // The last beat of a line is presented with busy already low.
  `LPR_ASSERT_SAME(a_free_after_last, clk, rst, strobe && last, !busy)
  // While busy, the beat on the ports is never the final one.
  `LPR_ASSERT_SAME(a_busy_not_last, clk, rst, busy, strobe && !last)

endmodule

>>> design/lpr_datapath.sv
module lpr_datapath (
  input  logic             clk,
  input  lpr_pkg::dp_cmd_t cmd,
  output lpr_pkg::dp_stat_t stat,
  input  lpr_pkg::coord_t  x_start,
  input  lpr_pkg::coord_t  y_start,
  input  lpr_pkg::coord_t  x_end,
  input  lpr_pkg::coord_t  y_end,
  output lpr_pkg::coord_t  pixel_x,
  output lpr_pkg::coord_t  pixel_y,
  output logic             last
);

  lpr_pkg::coord_t adx, ady, dmaj_in, dmin_in, maj_in, min_in;
  logic            ymajor_in, maj_neg_in, min_neg_in;

  lpr_pkg::coord_t maj, mn, cnt, dmaj, dmin;
  lpr_pkg::err_t   err;
  logic            ymajor, maj_neg, min_neg;

  lpr_pkg::coord_t maj_next, mn_next;
  lpr_pkg::err_t   err_sum, err_next;

  // Set-up for a new line.
  always_comb begin
    adx = (x_end > x_start) ? lpr_pkg::coord_t'(x_end - x_start)
                            : lpr_pkg::coord_t'(x_start - x_end);
    ady = (y_end > y_start) ? lpr_pkg::coord_t'(y_end - y_start)
                            : lpr_pkg::coord_t'(y_start - y_end);
    ymajor_in = ady > adx;
    if (ymajor_in) begin
      dmaj_in    = ady;
      dmin_in    = adx;
      maj_in     = y_start;
      min_in     = x_start;
      maj_neg_in = y_end < y_start;
      min_neg_in = x_end < x_start;
    end else begin
      dmaj_in    = adx;
      dmin_in    = ady;
      maj_in     = x_start;
      min_in     = y_start;
      maj_neg_in = x_end < x_start;
      min_neg_in = y_end < y_start;
    end
  end

  // One major step of the integer error recurrence.
  always_comb begin
    maj_next = maj_neg ? lpr_pkg::coord_t'(maj - lpr_pkg::coord_t'(1))
                       : lpr_pkg::coord_t'(maj + lpr_pkg::coord_t'(1));
    err_sum  = lpr_pkg::err_t'(err + lpr_pkg::err_t'({dmin, 1'b0}));
    if (!err_sum[lpr_pkg::ERR_BITS-1] && (err_sum != '0)) begin
      err_next = lpr_pkg::err_t'(err_sum - lpr_pkg::err_t'({dmaj, 1'b0}));
      mn_next  = min_neg ? lpr_pkg::coord_t'(mn - lpr_pkg::coord_t'(1))
                         : lpr_pkg::coord_t'(mn + lpr_pkg::coord_t'(1));
    end else begin
      err_next = err_sum;
      mn_next  = mn;
    end
  end

  assign stat.single     = (dmaj_in == '0);
  assign stat.final_step = (cnt == lpr_pkg::coord_t'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      maj     <= maj_in;
      mn      <= min_in;
      dmaj    <= dmaj_in;
      dmin    <= dmin_in;
      cnt     <= dmaj_in;
      err     <= lpr_pkg::err_t'(-lpr_pkg::err_t'(dmaj_in));
      ymajor  <= ymajor_in;
      maj_neg <= maj_neg_in;
      min_neg <= min_neg_in;
      pixel_x <= x_start;
      pixel_y <= y_start;
      last    <= (dmaj_in == '0);
    end else if (cmd.step) begin
      maj     <= maj_next;
      mn      <= mn_next;
      err     <= err_next;
      cnt     <= lpr_pkg::coord_t'(cnt - lpr_pkg::coord_t'(1));
      pixel_x <= ymajor ? mn_next : maj_next;
      pixel_y <= ymajor ? maj_next : mn_next;
      last    <= (cnt == lpr_pkg::coord_t'(1));
    end
  end

endmodule

>>> design/lpr_ctrl.sv
module lpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              strobe,
  output lpr_pkg::dp_cmd_t  cmd,
  input  lpr_pkg::dp_stat_t stat
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;

  assign busy = (state == RUN);

  always_comb begin
    cmd.load = (state == IDLE) && start;
    cmd.step = (state == RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          strobe <= start;
          if (start && !stat.single) begin
            state <= RUN;
          end
        end
        RUN: begin
          strobe <= 1'b1;
          if (stat.final_step) begin
            state <= IDLE;
          end
        end
        default: begin
          state  <= IDLE;
          strobe <= 1'b0;
        end
      endcase
    end
  end

endmodule
